// ===== hdl/hs_pkg.sv =====
// ----------------------------------------------------------------------------
// hs_pkg
// Shared constants and the command / status bundles between the heap sorter
// controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hs_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int VALUE_W       = 32;

	// one bit per datapath action, raised by the controller
	typedef struct packed {
		logic load;        // store the incoming element
		logic clear;       // empty the set
		logic build_init;  // idx = count / 2, heap length = count
		logic rd_node;     // read entry idx, node = idx
		logic ld_cur;      // hold the entry read as the value being sifted
		logic rd_kids;     // read both children of node
		logic sift_step;   // one level of sift-down
		logic idx_dec;     // step the loop index down
		logic sort_init;   // idx = count - 1
		logic rd_swap;     // read root and entry idx, node = 0, length = idx
		logic swap_step;   // old root goes to idx, entry idx is sifted
		logic out_init;    // idx = 0
		logic rd_out;      // read entry idx for output
		logic out_load;    // fill the output register
	} hs_cmd_t;

	typedef struct packed {
		logic sift_done;   // sifted value has found its place
		logic idx_zero;
		logic idx_one;
		logic cnt_zero;
		logic cnt_lt2;
		logic out_taken;   // output transaction completes this cycle
		logic out_last;    // output register holds the final element
	} hs_status_t;

endpackage

`default_nettype wire

// ===== hdl/hs_datapath.sv =====
// ----------------------------------------------------------------------------
// hs_datapath
// Element store, counters, sift-down compare logic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hs_datapath import hs_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hs_cmd_t            cmd,
	output      hs_status_t         status,
	input  wire logic [VALUE_W-1:0] value,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic [VALUE_W-1:0] sorted_value,
	output      logic               last_out,
	output      logic               dropped
);

	localparam int AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNTW = $clog2(MAX_ITEMS + 1);
	localparam int CW   = AW + 2;

	logic [VALUE_W-1:0] mem [0:MAX_ITEMS-1];
	logic [VALUE_W-1:0] rdata_a_q;
	logic [VALUE_W-1:0] rdata_b_q;

	logic [CNTW-1:0]    count_q;
	logic               ovf_q;
	logic [CNTW-1:0]    idx_q;
	logic [CNTW-1:0]    len_q;
	logic [AW-1:0]      node_q;
	logic [VALUE_W-1:0] cur_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] sorted_q;
	logic               last_q;
	logic               dropped_q;

	logic [CW-1:0]      l_idx;
	logic [CW-1:0]      r_idx;
	logic [CW-1:0]      len_ext;
	logic               take_l;
	logic               take_r;
	logic [VALUE_W-1:0] big_val;
	logic               done;
	logic [AW-1:0]      raddr_a;
	logic [AW-1:0]      raddr_b;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [VALUE_W-1:0] wdata;
	logic               has_room;
	logic               out_taken;
	logic [CNTW-1:0]    idx_next;

	always_comb begin
		l_idx    = {1'b0, node_q, 1'b1};
		r_idx    = l_idx + CW'(1);
		len_ext  = CW'(len_q);
		take_l   = (l_idx < len_ext) && (rdata_a_q > cur_q);
		big_val  = take_l ? rdata_a_q : cur_q;
		take_r   = (r_idx < len_ext) && (rdata_b_q > big_val);
		done     = !take_l && !take_r;
		has_room = count_q < CNTW'(MAX_ITEMS);
		out_taken = out_valid_q && out_ready;
		idx_next = idx_q + CNTW'(1);
	end

	always_comb begin
		raddr_a = idx_q[AW-1:0];
		raddr_b = idx_q[AW-1:0];
		if (cmd.rd_kids) begin
			raddr_a = l_idx[AW-1:0];
			raddr_b = r_idx[AW-1:0];
		end else if (cmd.rd_swap) begin
			raddr_a = '0;
		end else if (cmd.rd_out) begin
			raddr_a = idx_q[AW-1:0];
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = node_q;
		wdata = cur_q;
		if (cmd.load) begin
			we    = has_room;
			waddr = count_q[AW-1:0];
			wdata = value;
		end else if (cmd.sift_step) begin
			we    = 1'b1;
			waddr = node_q;
			wdata = done ? cur_q : (take_r ? rdata_b_q : rdata_a_q);
		end else if (cmd.swap_step) begin
			we    = 1'b1;
			waddr = idx_q[AW-1:0];
			wdata = rdata_a_q;
		end
	end

	// single write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	always_ff @(posedge clk) begin
		if (cmd.build_init) begin
			idx_q <= count_q >> 1;
			len_q <= count_q;
		end else if (cmd.sort_init) begin
			idx_q <= count_q - CNTW'(1);
		end else if (cmd.out_init) begin
			idx_q <= '0;
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - CNTW'(1);
		end else if (cmd.out_load) begin
			idx_q <= idx_next;
		end
		if (cmd.rd_swap) begin
			len_q <= idx_q;
		end

		if (cmd.rd_node) begin
			node_q <= idx_q[AW-1:0];
		end else if (cmd.rd_swap) begin
			node_q <= '0;
		end else if (cmd.sift_step && !done) begin
			node_q <= take_r ? r_idx[AW-1:0] : l_idx[AW-1:0];
		end

		if (cmd.ld_cur) begin
			cur_q <= rdata_a_q;
		end else if (cmd.swap_step) begin
			cur_q <= rdata_b_q;
		end

		if (cmd.out_load) begin
			sorted_q  <= rdata_a_q;
			last_q    <= (idx_next == count_q);
			dropped_q <= (idx_next == count_q) && ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.load) begin
				if (has_room) begin
					count_q <= count_q + CNTW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status.sift_done = done;
		status.idx_zero  = (idx_q == '0);
		status.idx_one   = (idx_q == CNTW'(1));
		status.cnt_zero  = (count_q == '0);
		status.cnt_lt2   = (count_q < CNTW'(2));
		status.out_taken = out_taken;
		status.out_last  = last_q;
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = sorted_q;
	assign last_out     = last_q;
	assign dropped      = dropped_q;

endmodule

`default_nettype wire

// ===== hdl/hs_ctrl.sv =====
// ----------------------------------------------------------------------------
// hs_ctrl
// Sequencer for loading, heap build, sort-down and output of one set.
// ----------------------------------------------------------------------------
`default_nettype none

module hs_ctrl import hs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic       last_in,
	input  wire hs_status_t status,
	output      hs_cmd_t    cmd
);

	localparam logic [3:0] ST_LOAD     = 4'd0;
	localparam logic [3:0] ST_START    = 4'd1;
	localparam logic [3:0] ST_B_RD     = 4'd2;
	localparam logic [3:0] ST_B_CUR    = 4'd3;
	localparam logic [3:0] ST_SIFT_RD  = 4'd4;
	localparam logic [3:0] ST_SIFT_CMP = 4'd5;
	localparam logic [3:0] ST_SWAP_RD  = 4'd6;
	localparam logic [3:0] ST_SWAP     = 4'd7;
	localparam logic [3:0] ST_OUT_RD   = 4'd8;
	localparam logic [3:0] ST_OUT_LD   = 4'd9;
	localparam logic [3:0] ST_OUT_WAIT = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       sort_q;
	logic       sort_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		sort_nxt  = sort_q;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_in) begin
						state_nxt = ST_START;
					end
				end
			end
			ST_START: begin
				sort_nxt = 1'b0;
				if (status.cnt_zero) begin
					cmd.clear = 1'b1;
					state_nxt = ST_LOAD;
				end else if (status.cnt_lt2) begin
					cmd.out_init = 1'b1;
					state_nxt    = ST_OUT_RD;
				end else begin
					cmd.build_init = 1'b1;
					state_nxt      = ST_B_RD;
				end
			end
			ST_B_RD: begin
				cmd.rd_node = 1'b1;
				state_nxt   = ST_B_CUR;
			end
			ST_B_CUR: begin
				cmd.ld_cur = 1'b1;
				state_nxt  = ST_SIFT_RD;
			end
			ST_SIFT_RD: begin
				cmd.rd_kids = 1'b1;
				state_nxt   = ST_SIFT_CMP;
			end
			ST_SIFT_CMP: begin
				cmd.sift_step = 1'b1;
				if (!status.sift_done) begin
					state_nxt = ST_SIFT_RD;
				end else if (!sort_q) begin
					// heap build walks parents from the middle down to the root
					if (status.idx_zero) begin
						cmd.sort_init = 1'b1;
						sort_nxt      = 1'b1;
						state_nxt     = ST_SWAP_RD;
					end else begin
						cmd.idx_dec = 1'b1;
						state_nxt   = ST_B_RD;
					end
				end else if (status.idx_one) begin
					cmd.out_init = 1'b1;
					state_nxt    = ST_OUT_RD;
				end else begin
					cmd.idx_dec = 1'b1;
					state_nxt   = ST_SWAP_RD;
				end
			end
			ST_SWAP_RD: begin
				cmd.rd_swap = 1'b1;
				state_nxt   = ST_SWAP;
			end
			ST_SWAP: begin
				cmd.swap_step = 1'b1;
				state_nxt     = ST_SIFT_RD;
			end
			ST_OUT_RD: begin
				cmd.rd_out = 1'b1;
				state_nxt  = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				cmd.out_load = 1'b1;
				state_nxt    = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				if (status.out_taken) begin
					if (status.out_last) begin
						cmd.clear = 1'b1;
						state_nxt = ST_LOAD;
					end else begin
						state_nxt = ST_OUT_RD;
					end
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			sort_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			sort_q  <= sort_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/heap_sorter.sv =====
// ----------------------------------------------------------------------------
// heap_sorter
// Collects a set of unsigned 32-bit values and returns them in ascending
// order using an in-place max-heap sort over a single element store.
//
// Input channel (in_valid/in_ready): one value per transaction; last_in marks
// the final value of a set. Values taken while the store holds MAX_ITEMS
// entries are discarded, but a discarded last_in still ends the set.
// While loading, in_ready stays high through the value marked last_in.
// After the last value the set is sorted in place: each sift-down level
// reads both children, then compares and writes; each sift starts by
// reading and loading the value to sift. The heap build runs N/2+1 sifts
// and the sort-down N-1.
// Output channel (out_valid/out_ready): one sorted value per transaction,
// each loaded only after the previous is taken; last_out marks the final
// value and dropped on it reports values lost to a full store.
// in_ready is low from the end of a set until its final result is taken.
// A stalled receiver holds the output register; the block waits.
// Reset empties the set and drops any result in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sorter import hs_pkg::*; #(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic               last_in,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic [VALUE_W-1:0] sorted_value,
	output      logic               last_out,
	output      logic               dropped
);

	hs_cmd_t    cmd;
	hs_status_t status;

	hs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.last_in  (last_in),
		.status   (status),
		.cmd      (cmd)
	);

	hs_datapath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.dropped      (dropped)
	);

endmodule

`default_nettype wire
